[src/skcm_pkg.sv]
// ----------------------------------------------------------------------------
// skcm_pkg: shared constants and types for the sorted key-count merger
// Holds default sizes, the port field widths and the sequencer states.
// ----------------------------------------------------------------------------
package skcm_pkg;

  localparam int unsigned DefDepth     = 64;
  localparam int unsigned DefKeyBits   = 64;
  localparam int unsigned DefCountBits = 8;

  // Port field widths (fixed by the stream format)
  localparam int unsigned KeyW   = 64;
  localparam int unsigned CountW = 8;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    StIdle   = 6'b000001,  // waiting for a word
    StSearch = 6'b000010,  // scanning for key position
    StShift  = 6'b000100,  // opening a slot by moving pairs up
    StWrite  = 6'b001000,  // merge or place the new pair
    StEmit   = 6'b010000,  // streaming held pairs out
    StOvf    = 6'b100000   // single overflow word out
  } state_e;

endpackage

[src/skcm_store.sv]
// ----------------------------------------------------------------------------
// skcm_store: pair memory (key and count) with one write and one read port
// Synchronous read: the read data is registered.
// ----------------------------------------------------------------------------
module skcm_store #(
  parameter int unsigned Depth     = skcm_pkg::DefDepth,
  parameter int unsigned KeyBits   = skcm_pkg::DefKeyBits,
  parameter int unsigned CountBits = skcm_pkg::DefCountBits,
  localparam int unsigned AddrW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [KeyBits-1:0]   wkey_i,
  input  logic [CountBits-1:0] wcount_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [KeyBits-1:0]   rkey_o,
  output logic [CountBits-1:0] rcount_o
);

  logic [KeyBits-1:0]   key_mem [Depth];
  logic [CountBits-1:0] cnt_mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      cnt_mem[waddr_i] <= wcount_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rkey_o   <= key_mem[raddr_i];
    rcount_o <= cnt_mem[raddr_i];
  end

endmodule

[src/sorted_key_count_merger.sv]
// ----------------------------------------------------------------------------
// sorted_key_count_merger: sorted store of (key, count) pairs with merging
// Busy: after a word is taken the block scans the pairs below the key, moves
//   pairs up to open a slot where needed and writes, then returns to idle.
// Flush: the first read is started, then one word per held pair per cycle while the output is not stalled.
// Overflow without flush gives one word. One item is in work at a time.
// Reset (rst_ni low, asynchronous) empties the store; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_key_count_merger #(
  parameter int unsigned Depth     = skcm_pkg::DefDepth,
  parameter int unsigned KeyBits   = skcm_pkg::DefKeyBits,
  parameter int unsigned CountBits = skcm_pkg::DefCountBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // [63:0] key, [71:64] count
  input  logic        s_axis_tlast,   // flush
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] out_key, [71:64] out_count
  output logic        m_axis_tlast,   // last_pair
  output logic        m_axis_tuser    // overflow
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned KW    = skcm_pkg::KeyW;
  localparam int unsigned CW    = skcm_pkg::CountW;
  localparam int unsigned SatW  = (CountBits < CW) ? CountBits : CW;

  skcm_pkg::state_e state_q, state_d;

  logic [CntW-1:0]      held_q, held_d;
  logic [CntW-1:0]      pos_q, pos_d;      // scan / emit index
  logic [CntW-1:0]      sh_q, sh_d;        // shift cursor
  logic [KeyBits-1:0]   key_q, key_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 flush_q, flush_d;
  logic                 drop_q, drop_d;
  logic                 rd_ok_q, rd_ok_d;  // read data belongs to the cursor
  logic                 match_q, match_d;

  // output skid register
  logic          ov_q, ov_d;
  logic [KW-1:0] ok_q, ok_d;
  logic [CW-1:0] oc_q, oc_d;
  logic          ol_q, ol_d, of_q, of_d;

  logic                 we;
  logic [AddrW-1:0]     waddr, raddr;
  logic [KeyBits-1:0]   wkey, rkey;
  logic [CountBits-1:0] wcnt, rcnt;

  logic                 out_free;
  logic [CountBits:0]   sum;
  logic [CountBits-1:0] sat;

  skcm_store #(
    .Depth(Depth), .KeyBits(KeyBits), .CountBits(CountBits)
  ) u_store (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wkey_i(wkey), .wcount_i(wcnt),
    .raddr_i(raddr), .rkey_o(rkey), .rcount_o(rcnt)
  );

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == skcm_pkg::StIdle) && out_free;
  assign sum = {1'b0, rcnt} + {1'b0, cnt_q};
  assign sat = sum[CountBits] ? {CountBits{1'b1}} : sum[CountBits-1:0];

  // sequencer
  always_comb begin
    state_d = state_q;
    held_d  = held_q;
    pos_d   = pos_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    flush_d = flush_q;
    drop_d  = drop_q;
    rd_ok_d = 1'b0;
    match_d = match_q;
    ov_d = ov_q && !m_axis_tready;
    ok_d = ok_q; oc_d = oc_q; ol_d = ol_q; of_d = of_q;
    we = 1'b0;
    waddr = pos_q[AddrW-1:0];
    wkey  = key_q;
    wcnt  = cnt_q;
    raddr = pos_q[AddrW-1:0];
    case (state_q)
      skcm_pkg::StIdle: begin
        raddr = '0;
        if (s_axis_tvalid && s_axis_tready) begin
          key_d   = s_axis_tdata[KeyBits-1:0];
          cnt_d   = {CountBits{1'b0}};
          cnt_d[SatW-1:0] = s_axis_tdata[KW +: SatW];
          flush_d = s_axis_tlast;
          drop_d  = 1'b0;
          match_d = 1'b0;
          pos_d   = '0;
          rd_ok_d = 1'b1;
          state_d = skcm_pkg::StSearch;
        end
      end
      skcm_pkg::StSearch: begin
        // pos_q points at the pair whose read data is valid now
        if (!rd_ok_q) begin
          rd_ok_d = 1'b1;
        end else if (pos_q < held_q && rkey < key_q) begin
          pos_d   = pos_q + 1'b1;
          raddr   = pos_d[AddrW-1:0];
          rd_ok_d = 1'b1;
        end else if (pos_q < held_q && rkey == key_q) begin
          match_d = 1'b1;
          cnt_d   = sat;
          state_d = skcm_pkg::StWrite;
        end else if (held_q == CntW'(Depth)) begin
          drop_d  = 1'b1;
          state_d = flush_q ? skcm_pkg::StWrite : skcm_pkg::StOvf;
        end else begin
          // open a slot: move held-1 .. pos_q up by one, top first
          state_d = (held_q == pos_q) ? skcm_pkg::StWrite : skcm_pkg::StShift;
          raddr   = AddrW'(held_q - 1'b1);
          rd_ok_d = 1'b1;
        end
      end
      skcm_pkg::StShift: begin
        // read data is pair sh_q; it moves to sh_q + 1
        raddr = sh_q[AddrW-1:0];
        if (rd_ok_q) begin
          we    = 1'b1;
          waddr = AddrW'(sh_q + 1'b1);
          wkey  = rkey;
          wcnt  = rcnt;
          if (sh_q == pos_q) begin
            state_d = skcm_pkg::StWrite;
          end else begin
            raddr   = AddrW'(sh_q - 1'b1);
            rd_ok_d = 1'b1;
          end
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      skcm_pkg::StWrite: begin
        if (!drop_q) begin
          we = 1'b1;
          if (!match_q) held_d = held_q + 1'b1;
        end
        if (flush_q) begin
          // first read is issued in emit, after this write has landed
          pos_d   = '0;
          state_d = skcm_pkg::StEmit;
        end else begin
          state_d = skcm_pkg::StIdle;
        end
      end
      skcm_pkg::StEmit: begin
        raddr = pos_q[AddrW-1:0];
        if (rd_ok_q && out_free) begin
          ov_d = 1'b1;
          ok_d = KW'(rkey);
          oc_d = CW'(rcnt);
          ol_d = (pos_q + 1'b1 == held_q);
          of_d = ol_d && drop_q;
          if (ol_d) begin
            state_d = skcm_pkg::StIdle;
          end else begin
            pos_d = pos_q + 1'b1;
            raddr = pos_d[AddrW-1:0];
          end
        end
        rd_ok_d = 1'b1;
      end
      skcm_pkg::StOvf: begin
        if (out_free) begin
          ov_d = 1'b1;
          ok_d = KW'(key_q);
          oc_d = '0;
          ol_d = 1'b0;
          of_d = 1'b1;
          state_d = skcm_pkg::StIdle;
        end
      end
      default: state_d = skcm_pkg::StIdle;
    endcase
  end

  // shift cursor: from held-1 down to pos
  always_comb begin
    sh_d = sh_q;
    if (state_q == skcm_pkg::StSearch) sh_d = held_q - 1'b1;
    else if (state_q == skcm_pkg::StShift && rd_ok_q) sh_d = sh_q - 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skcm_pkg::StIdle;
      held_q  <= '0;
      rd_ok_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      held_q  <= held_d;
      rd_ok_q <= rd_ok_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; key_q <= key_d; cnt_q <= cnt_d; sh_q <= sh_d;
    flush_q <= flush_d; drop_q <= drop_d; match_q <= match_d;
    ok_q <= ok_d; oc_q <= oc_d; ol_q <= ol_d; of_q <= of_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {oc_q, ok_q};
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = of_q;

  // checks
  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= CntW'(Depth)) else $error("held count above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != skcm_pkg::StIdle |-> !s_axis_tready) else $error("ready while busy");
  a_held_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != $past(held_q) |-> held_q == $past(held_q) + 1'b1)
    else $error("held count jumped");

endmodule
